// File: hw/rtl/mfap_pkg.sv
// Shared types and constants for the max-flow augmenting-path engine.
`default_nettype none
package mfap_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int CAP_BITS_DEF  = 32;

  localparam int NODE_W = 4;
  localparam int CAPIN_W = 32;
  localparam int RES_W  = 40;
  localparam int FLOW_W = 48;
  localparam int ALU_W  = 48;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_RUN   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ADD_WR,
    ST_QRY,
    ST_BFS_INIT,
    ST_BFS_POP,
    ST_BFS_POPW,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_AUG_START,
    ST_AUG_CHK,
    ST_AUG_PRD,
    ST_AUG_PWT,
    ST_AUG_FW,
    ST_AUG_BW
  } state_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage
`default_nettype wire

// File: hw/rtl/mfap_alu.sv
// Shared add/subtract unit with carry-out, used for the residual and flow sums, differences and the bottleneck compare.
`default_nettype none
module mfap_alu (
  input  wire logic [mfap_pkg::ALU_W-1:0] a,
  input  wire logic [mfap_pkg::ALU_W-1:0] b,
  input  wire mfap_pkg::alu_op_t          op,
  output logic      [mfap_pkg::ALU_W:0]   sum
);

  always_comb begin
    unique case (op)
      mfap_pkg::ALU_SUB: sum = {1'b0, a} - {1'b0, b};
      default:           sum = {1'b0, a} + {1'b0, b};
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/mfap_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module mfap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/max_flow_augmenting_path_top.sv
// Edmonds-Karp max-flow engine: one transaction in, one result transaction out.
// Input channel (in_*): opcode 0 adds or replaces edge node_from->node_to,
// opcode 1 runs max flow from node_from to node_to, opcode 2 queries an edge.
// Every input transaction yields exactly one output transaction (out_*).
// The block takes one transaction at a time; in_stall is high while it works.
// Add and query go through the decode state and then a write or read state;
// their result is held pending and then loaded into the output register. A
// run repeats breadth-first searches, scanning the matrix row of each popped
// vertex, and augments each path found; the matrix memory has one read port.
// After reset the residual matrix is cleared one entry per cycle, with
// in_stall high until every entry has been written.
// The result sits in an output register; a new transaction is accepted while
// it waits, and the next result is held back until out_stall drops.
`default_nettype none
module max_flow_augmenting_path_top #(
  parameter int MAX_NODES = mfap_pkg::MAX_NODES_DEF,
  parameter int CAP_BITS  = mfap_pkg::CAP_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_opcode,
  input  wire logic [mfap_pkg::NODE_W-1:0]   in_node_from,
  input  wire logic [mfap_pkg::NODE_W-1:0]   in_node_to,
  input  wire logic [mfap_pkg::CAPIN_W-1:0]  in_capacity,
  input  wire logic                          in_replace,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [mfap_pkg::FLOW_W-1:0]   out_total_flow,
  output logic                               out_edge_used,
  output logic      [mfap_pkg::RES_W-1:0]    out_residual
);

  localparam int VW = $clog2(MAX_NODES);
  localparam int NODE_SLOTS = MAX_NODES * MAX_NODES;
  localparam int AW = $clog2(NODE_SLOTS);
  localparam int QW = $clog2(MAX_NODES + 1);
  localparam int RW = mfap_pkg::RES_W;
  localparam int FW = mfap_pkg::FLOW_W;
  localparam int XW = mfap_pkg::ALU_W;
  localparam int CAP_USE = (CAP_BITS < mfap_pkg::CAPIN_W) ? CAP_BITS : mfap_pkg::CAPIN_W;
  localparam logic [mfap_pkg::CAPIN_W-1:0] CAP_MASK =
    mfap_pkg::CAPIN_W'((64'd1 << CAP_USE) - 64'd1);
  localparam logic [RW-1:0] RES_MAX  = '1;
  localparam logic [FW-1:0] FLOW_MAX = '1;

  function automatic logic [AW-1:0] slot(input logic [VW-1:0] row, input logic [VW-1:0] col);
    return AW'(AW'(row) * AW'(MAX_NODES)) + AW'(col);
  endfunction

  mfap_pkg::state_t state_r, state_nxt;
  mfap_pkg::op_t    op_r, op_nxt;
  logic             ok_r, ok_nxt;
  logic [VW-1:0]    s_r, s_nxt, t_r, t_nxt;
  logic [mfap_pkg::CAPIN_W-1:0] cap_r, cap_nxt;
  logic             rep_r, rep_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [VW-1:0]    cur_r, cur_nxt, nx_r, nx_nxt, prev_r, prev_nxt;
  logic [RW-1:0]    fl_r, fl_nxt, bneck_r, bneck_nxt;
  logic [QW-1:0]    head_r, head_nxt, tail_r, tail_nxt, steps_r, steps_nxt;
  logic [MAX_NODES-1:0] visited_r, visited_nxt;
  logic [FW-1:0]    total_r, total_nxt;
  logic [FW-1:0]    rslt_flow_r, rslt_flow_nxt;
  logic             rslt_used_r, rslt_used_nxt;
  logic [RW-1:0]    rslt_res_r, rslt_res_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [FW-1:0]    out_flow_r, out_flow_nxt;
  logic             out_used_r, out_used_nxt;
  logic [RW-1:0]    out_res_r, out_res_nxt;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [RW:0]      mem_wdata, mem_rdata;
  logic             q_we;
  logic [VW-1:0]    q_waddr, q_raddr;
  logic [VW+RW-1:0] q_wdata, q_rdata;
  logic             par_we;
  logic [VW-1:0]    par_waddr, par_wdata, par_raddr, par_rdata;

  logic [XW-1:0]    alu_a, alu_b;
  mfap_pkg::alu_op_t alu_op;
  logic [XW:0]      alu_sum;
  logic [RW-1:0]    res_rd, nf, res_sat, res_dif;

  mfap_alu u_alu (.a(alu_a), .b(alu_b), .op(alu_op), .sum(alu_sum));

  mfap_ram #(.WIDTH(RW + 1), .DEPTH(NODE_SLOTS)) u_matrix (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  mfap_ram #(.WIDTH(VW + RW), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  mfap_ram #(.WIDTH(VW), .DEPTH(MAX_NODES)) u_parent (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rdata)
  );

  assign res_rd  = mem_rdata[RW-1:0];
  assign res_sat = (|alu_sum[XW:RW]) ? RES_MAX : alu_sum[RW-1:0];
  assign res_dif = alu_sum[XW] ? '0 : alu_sum[RW-1:0];
  assign nf      = alu_sum[XW] ? fl_r : res_rd;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ok_nxt        = ok_r;
    s_nxt         = s_r;
    t_nxt         = t_r;
    cap_nxt       = cap_r;
    rep_nxt       = rep_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    nx_nxt        = nx_r;
    prev_nxt      = prev_r;
    fl_nxt        = fl_r;
    bneck_nxt     = bneck_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    steps_nxt     = steps_r;
    visited_nxt   = visited_r;
    total_nxt     = total_r;
    rslt_flow_nxt = rslt_flow_r;
    rslt_used_nxt = rslt_used_r;
    rslt_res_nxt  = rslt_res_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_flow_nxt  = out_flow_r;
    out_used_nxt  = out_used_r;
    out_res_nxt   = out_res_r;
    mem_we        = 1'b0;
    mem_waddr     = slot(s_r, t_r);
    mem_wdata     = '0;
    mem_raddr     = slot(s_r, t_r);
    q_we          = 1'b0;
    q_waddr       = tail_r[VW-1:0];
    q_wdata       = {nx_r, nf};
    q_raddr       = head_r[VW-1:0];
    par_we        = 1'b0;
    par_waddr     = nx_r;
    par_wdata     = cur_r;
    par_raddr     = cur_r;
    alu_a         = '0;
    alu_b         = '0;
    alu_op        = mfap_pkg::ALU_ADD;

    // Drain the output register, then load a pending result.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (pend_r && (!out_valid_r || !out_stall)) begin
      out_valid_nxt = 1'b1;
      out_flow_nxt  = rslt_flow_r;
      out_used_nxt  = rslt_used_r;
      out_res_nxt   = rslt_res_r;
      pend_nxt      = 1'b0;
    end

    unique case (state_r)
      mfap_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(NODE_SLOTS - 1)) begin
          state_nxt = mfap_pkg::ST_IDLE;
        end
      end
      mfap_pkg::ST_IDLE: begin
        if (in_valid && !pend_r) begin
          op_nxt    = mfap_pkg::op_t'(in_opcode);
          ok_nxt    = (32'(in_node_from) < MAX_NODES) && (32'(in_node_to) < MAX_NODES);
          s_nxt     = VW'(in_node_from);
          t_nxt     = VW'(in_node_to);
          cap_nxt   = in_capacity & CAP_MASK;
          rep_nxt   = in_replace;
          state_nxt = mfap_pkg::ST_DECODE;
        end
      end
      mfap_pkg::ST_DECODE: begin
        rslt_flow_nxt = '0;
        rslt_used_nxt = 1'b0;
        rslt_res_nxt  = '0;
        total_nxt     = '0;
        state_nxt     = mfap_pkg::ST_IDLE;
        pend_nxt      = 1'b1;
        if (ok_r) begin
          unique case (op_r)
            mfap_pkg::OP_ADD: begin
              pend_nxt  = 1'b0;
              state_nxt = mfap_pkg::ST_ADD_WR;
            end
            mfap_pkg::OP_QUERY: begin
              pend_nxt  = 1'b0;
              state_nxt = mfap_pkg::ST_QRY;
            end
            mfap_pkg::OP_RUN: begin
              if (s_r != t_r) begin
                pend_nxt  = 1'b0;
                state_nxt = mfap_pkg::ST_BFS_INIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      mfap_pkg::ST_ADD_WR: begin
        alu_a     = XW'(res_rd);
        alu_b     = XW'(cap_r);
        mem_we    = 1'b1;
        mem_wdata = {1'b1, rep_r ? RW'(cap_r) : res_sat};
        pend_nxt  = 1'b1;
        state_nxt = mfap_pkg::ST_IDLE;
      end
      mfap_pkg::ST_QRY: begin
        rslt_res_nxt  = res_rd;
        rslt_used_nxt = mem_rdata[RW] && (res_rd == '0);
        pend_nxt      = 1'b1;
        state_nxt     = mfap_pkg::ST_IDLE;
      end
      mfap_pkg::ST_BFS_INIT: begin
        visited_nxt       = '0;
        visited_nxt[s_r]  = 1'b1;
        q_we              = 1'b1;
        q_waddr           = '0;
        q_wdata           = {s_r, RES_MAX};
        par_we            = 1'b1;
        par_waddr         = s_r;
        par_wdata         = s_r;
        head_nxt          = '0;
        tail_nxt          = QW'(1);
        state_nxt         = mfap_pkg::ST_BFS_POP;
      end
      mfap_pkg::ST_BFS_POP: begin
        if (head_r == tail_r) begin
          // No path left: report the run.
          rslt_flow_nxt = total_r;
          pend_nxt      = 1'b1;
          state_nxt     = mfap_pkg::ST_IDLE;
        end else begin
          head_nxt  = head_r + 1'b1;
          state_nxt = mfap_pkg::ST_BFS_POPW;
        end
      end
      mfap_pkg::ST_BFS_POPW: begin
        cur_nxt   = q_rdata[VW+RW-1:RW];
        fl_nxt    = q_rdata[RW-1:0];
        nx_nxt    = '0;
        state_nxt = mfap_pkg::ST_SCAN_RD;
      end
      mfap_pkg::ST_SCAN_RD: begin
        mem_raddr = slot(cur_r, nx_r);
        state_nxt = mfap_pkg::ST_SCAN_CHK;
      end
      mfap_pkg::ST_SCAN_CHK: begin
        alu_a  = XW'(fl_r);
        alu_b  = XW'(res_rd);
        alu_op = mfap_pkg::ALU_SUB;
        if (nx_r == VW'(MAX_NODES - 1)) begin
          state_nxt = mfap_pkg::ST_BFS_POP;
        end else begin
          nx_nxt    = nx_r + 1'b1;
          state_nxt = mfap_pkg::ST_SCAN_RD;
        end
        if (!visited_r[nx_r] && (res_rd != '0)) begin
          visited_nxt[nx_r] = 1'b1;
          par_we            = 1'b1;
          if (nx_r == t_r) begin
            bneck_nxt = nf;
            state_nxt = mfap_pkg::ST_AUG_START;
          end else if (tail_r < QW'(MAX_NODES)) begin
            q_we     = 1'b1;
            tail_nxt = tail_r + 1'b1;
          end
        end
      end
      mfap_pkg::ST_AUG_START: begin
        alu_a     = XW'(total_r);
        alu_b     = XW'(bneck_r);
        total_nxt = alu_sum[XW] ? FLOW_MAX : alu_sum[FW-1:0];
        cur_nxt   = t_r;
        steps_nxt = '0;
        state_nxt = mfap_pkg::ST_AUG_CHK;
      end
      mfap_pkg::ST_AUG_CHK: begin
        if ((cur_r == s_r) || (steps_r == QW'(MAX_NODES))) begin
          state_nxt = mfap_pkg::ST_BFS_INIT;
        end else begin
          state_nxt = mfap_pkg::ST_AUG_PRD;
        end
      end
      mfap_pkg::ST_AUG_PRD: begin
        state_nxt = mfap_pkg::ST_AUG_PWT;
      end
      mfap_pkg::ST_AUG_PWT: begin
        prev_nxt  = par_rdata;
        mem_raddr = slot(par_rdata, cur_r);
        state_nxt = mfap_pkg::ST_AUG_FW;
      end
      mfap_pkg::ST_AUG_FW: begin
        // Debit the forward edge, clamp at zero; fetch the reverse edge.
        alu_a     = XW'(res_rd);
        alu_b     = XW'(bneck_r);
        alu_op    = mfap_pkg::ALU_SUB;
        mem_we    = 1'b1;
        mem_waddr = slot(prev_r, cur_r);
        mem_wdata = {mem_rdata[RW], res_dif};
        mem_raddr = slot(cur_r, prev_r);
        state_nxt = mfap_pkg::ST_AUG_BW;
      end
      mfap_pkg::ST_AUG_BW: begin
        alu_a     = XW'(res_rd);
        alu_b     = XW'(bneck_r);
        mem_we    = 1'b1;
        mem_waddr = slot(cur_r, prev_r);
        mem_wdata = {mem_rdata[RW], res_sat};
        cur_nxt   = prev_r;
        steps_nxt = steps_r + 1'b1;
        state_nxt = mfap_pkg::ST_AUG_CHK;
      end
      default: begin
        state_nxt = mfap_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfap_pkg::ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    ok_r        <= ok_nxt;
    s_r         <= s_nxt;
    t_r         <= t_nxt;
    cap_r       <= cap_nxt;
    rep_r       <= rep_nxt;
    cur_r       <= cur_nxt;
    nx_r        <= nx_nxt;
    prev_r      <= prev_nxt;
    fl_r        <= fl_nxt;
    bneck_r     <= bneck_nxt;
    head_r      <= head_nxt;
    tail_r      <= tail_nxt;
    steps_r     <= steps_nxt;
    visited_r   <= visited_nxt;
    total_r     <= total_nxt;
    rslt_flow_r <= rslt_flow_nxt;
    rslt_used_r <= rslt_used_nxt;
    rslt_res_r  <= rslt_res_nxt;
    out_flow_r  <= out_flow_nxt;
    out_used_r  <= out_used_nxt;
    out_res_r   <= out_res_nxt;
  end

  assign in_stall       = (state_r != mfap_pkg::ST_IDLE) || pend_r;
  assign out_valid      = out_valid_r;
  assign out_total_flow = out_flow_r;
  assign out_edge_used  = out_used_r;
  assign out_residual   = out_res_r;

endmodule
`default_nettype wire

// File: hw/rtl/mfap_checker.sv
// Port-level checker for the max-flow engine, bound to the top level.
`default_nettype none
module mfap_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [mfap_pkg::FLOW_W-1:0]  out_total_flow,
  input wire logic                         out_edge_used,
  input wire logic [mfap_pkg::RES_W-1:0]   out_residual
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // One transaction at a time: busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while busy");

  a_used_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_used |-> (out_residual == '0) && (out_total_flow == '0))
    else $error("used edge reported with nonzero residual or flow");

  a_flow_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_total_flow != '0) |-> !out_edge_used && (out_residual == '0))
    else $error("run result carries query fields");

endmodule

bind max_flow_augmenting_path_top mfap_checker u_mfap_checker (.*);
`default_nettype wire
